/* rtl/eofh_pkg.sv */
package eofh_pkg;

    localparam logic [63:0] FNV_BASIS = 64'h14650fb0739d0383;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
    localparam logic [15:0] COOKIE_RESET = 16'd10;

    localparam logic ACT_DATA = 1'b0;
    localparam logic ACT_END  = 1'b1;

    typedef logic [63:0] t_hash;

    // multiply by the 64-bit prime as shifts and adds: bits 40, 8, 7, 5, 4, 1, 0
    function automatic t_hash fnv_step(input t_hash h, input logic [7:0] b);
        t_hash x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

/* rtl/edns_option_filter_hash_core.sv */
// Filters and hashes the data of an EDNS OPT record. Feed one word per byte
// (action low) and then one end word (action high). Options whose code equals
// the cookie code register (reset 10) are dropped; every byte of the other
// options, headers included, goes into a kept-byte count and a 64-bit hash
// (FNV-1a prime, nonstandard offset basis). Only the end word yields a result
// word: well_formed, kept_length and option_hash, with length and hash zero
// for a malformed record and the hash zero when nothing was kept. A new word
// is taken every cycle; each word is held in the input register while the
// parse and hash logic works on it, and a result enters the output register
// when its end word leaves the input register. The output register lets
// input continue while a result waits; only a second end word stalls behind
// an untaken result. Write the cookie code only while no record is in flight.
module edns_option_filter_hash_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [15:0]           i_cookie_option_code,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_action,
    input  logic [7:0]            i_data_byte,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_well_formed,
    output logic [15:0]           o_kept_length,
    output eofh_pkg::t_hash       o_option_hash
);
    import eofh_pkg::*;

    logic [15:0] r_cookie;

    logic        r_in_valid;
    logic        r_action;
    logic [7:0]  r_data;

    logic [1:0]  r_phase, n_phase;
    logic [23:0] r_hdr, n_hdr;
    logic [15:0] r_body, n_body;
    logic        r_skip, n_skip;
    t_hash       r_commit, n_commit;
    t_hash       r_tent, n_tent;
    logic [15:0] r_kept, n_kept;
    logic [16:0] r_bytes, n_bytes;

    logic        r_out_valid;
    logic        r_well_formed, n_well_formed;
    logic [15:0] r_kept_length, n_kept_length;
    t_hash       r_option_hash, n_option_hash;

    logic        advance;
    logic        is_end;

    assign is_end      = r_in_valid && (r_action == ACT_END);
    assign advance     = r_in_valid && (!is_end || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        logic [31:0] hdr_full;
        logic [15:0] body_dec;
        logic        ok;
        n_phase       = r_phase;
        n_hdr         = r_hdr;
        n_body        = r_body;
        n_skip        = r_skip;
        n_commit      = r_commit;
        n_tent        = r_tent;
        n_kept        = r_kept;
        n_bytes       = r_bytes;
        n_well_formed = 1'b0;
        n_kept_length = 16'd0;
        n_option_hash = '0;
        hdr_full      = {r_hdr, r_data};
        body_dec      = r_body - 16'd1;
        ok            = (r_phase == 2'd0) && (r_body == 16'd0) && !r_bytes[16];
        if (r_action == ACT_END) begin
            n_well_formed = ok;
            n_kept_length = ok ? r_kept : 16'd0;
            n_option_hash = (ok && r_kept != 16'd0) ? r_commit : '0;
            n_phase       = 2'd0;
            n_hdr         = '0;
            n_body        = 16'd0;
            n_skip        = 1'b0;
            n_commit      = FNV_BASIS;
            n_tent        = FNV_BASIS;
            n_kept        = 16'd0;
            n_bytes       = 17'd0;
        end else begin
            if (!r_bytes[16]) begin
                n_bytes = r_bytes + 17'd1;
            end
            if (r_body != 16'd0) begin
                if (!r_skip) begin
                    n_tent = fnv_step(r_tent, r_data);
                end
                n_body = body_dec;
                if (body_dec == 16'd0) begin
                    if (!r_skip) begin
                        n_commit = n_tent;
                        n_kept   = r_kept + r_hdr[15:0] + 16'd4;
                    end else begin
                        n_tent = r_commit;
                    end
                    n_skip = 1'b0;
                end
            end else begin
                n_tent  = fnv_step(r_tent, r_data);
                n_hdr   = hdr_full[23:0];
                n_phase = r_phase + 2'd1;
                if (r_phase == 2'd3) begin
                    n_skip = (hdr_full[31:16] == r_cookie);
                    n_body = hdr_full[15:0];
                    if (n_skip) begin
                        n_tent = r_commit;
                    end
                    // empty body closes the option at once
                    if (hdr_full[15:0] == 16'd0) begin
                        if (!n_skip) begin
                            n_commit = n_tent;
                            n_kept   = r_kept + 16'd4;
                        end
                        n_skip = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cookie <= COOKIE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cookie <= i_cookie_option_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_action <= i_action;
            r_data   <= i_data_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= 2'd0;
            r_hdr    <= '0;
            r_body   <= 16'd0;
            r_skip   <= 1'b0;
            r_commit <= FNV_BASIS;
            r_tent   <= FNV_BASIS;
            r_kept   <= 16'd0;
            r_bytes  <= 17'd0;
        end else if (advance) begin
            r_phase  <= n_phase;
            r_hdr    <= n_hdr;
            r_body   <= n_body;
            r_skip   <= n_skip;
            r_commit <= n_commit;
            r_tent   <= n_tent;
            r_kept   <= n_kept;
            r_bytes  <= n_bytes;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_end) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && is_end) begin
            r_well_formed <= n_well_formed;
            r_kept_length <= n_kept_length;
            r_option_hash <= n_option_hash;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_well_formed = r_well_formed;
    assign o_kept_length = r_kept_length;
    assign o_option_hash = r_option_hash;

endmodule

/* rtl/eofh_checker.sv */
module eofh_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  o_in_ready,
    input  logic                  i_action,
    input  logic                  o_out_valid,
    input  logic                  i_out_ready,
    input  logic                  o_well_formed,
    input  logic [15:0]           o_kept_length,
    input  eofh_pkg::t_hash       o_option_hash
);
    import eofh_pkg::*;

    // a waiting result word stays up
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before taken");

    // malformed records report zero length and hash
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_well_formed |-> o_kept_length == 16'd0 && o_option_hash == '0)
        else $error("malformed record with nonzero length or hash");

    // nothing kept gives a zero hash
    a_empty_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kept_length == 16'd0 |-> o_option_hash == '0)
        else $error("nonzero hash with nothing kept");

    // a data word taken while no result is pending never raises a result when it leaves the input register
    a_data_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_action == ACT_DATA && !o_out_valid
        ##1 !o_out_valid |=> !o_out_valid)
        else $error("result word without end word");

endmodule

bind edns_option_filter_hash_core eofh_checker u_eofh_checker (.*);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import eofh_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam logic [63:0] HASH_SEED = 64'd1469598103934665603;
    localparam logic [63:0] HASH_MULT = 64'd1099511628211;
    localparam logic [16:0] MAX_RECORD = 17'd65535;

    typedef struct packed {
        logic        well_formed;
        logic [15:0] kept_length;
        logic [63:0] option_hash;
    } t_record_summary;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_code = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        in_action = ACT_DATA;
    logic [7:0]  in_byte = 8'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        out_well_formed;
    logic [15:0] out_kept_length;
    t_hash       out_hash;

    // predictor state
    logic [15:0] cookie_code = COOKIE_RESET;
    logic [2:0]  hdr_count;
    logic [31:0] hdr_word;
    logic [15:0] body_left;
    logic        in_cookie;
    logic [63:0] hash_kept;
    logic [63:0] hash_open;
    logic [15:0] kept_bytes;
    logic [16:0] record_len;

    t_record_summary pending_results[$];
    t_record_summary want;
    logic [7:0]      record_buf[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_off = 0;
    int cycle_count = 0;
    int input_waits = 0;
    int words_sent = 0;
    int records_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int fault_count = 0;

    edns_option_filter_hash_core dut (
        .i_clk                (clk),
        .i_rst_n              (rst_n),
        .i_cfg_valid          (cfg_valid),
        .o_cfg_ready          (cfg_ready),
        .i_cookie_option_code (cfg_code),
        .i_in_valid           (in_valid),
        .o_in_ready           (in_ready),
        .i_action             (in_action),
        .i_data_byte          (in_byte),
        .o_out_valid          (out_valid),
        .i_out_ready          (out_ready),
        .o_well_formed        (out_well_formed),
        .o_kept_length        (out_kept_length),
        .o_option_hash        (out_hash)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic [63:0] hash_byte(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * HASH_MULT;
    endfunction

    function automatic void restart_record();
        hdr_count  = 3'd0;
        hdr_word   = 32'd0;
        body_left  = 16'd0;
        in_cookie  = 1'b0;
        hash_kept  = HASH_SEED;
        hash_open  = HASH_SEED;
        kept_bytes = 16'd0;
        record_len = 17'd0;
    endfunction

    function automatic void close_option();
        if (!in_cookie) begin
            hash_kept  = hash_open;
            kept_bytes = kept_bytes + hdr_word[15:0] + 16'd4;
        end else begin
            hash_open = hash_kept;
        end
        in_cookie = 1'b0;
    endfunction

    function automatic void track_word(input logic act, input logic [7:0] b);
        t_record_summary res;
        logic ok;
        if (act == ACT_END) begin
            ok = (hdr_count == 3'd0) && (body_left == 16'd0) && (record_len <= MAX_RECORD);
            res.well_formed = ok;
            res.kept_length = ok ? kept_bytes : 16'd0;
            res.option_hash = (ok && kept_bytes != 16'd0) ? hash_kept : 64'd0;
            pending_results.push_back(res);
            restart_record();
        end else begin
            if (record_len <= MAX_RECORD)
                record_len = record_len + 17'd1;
            if (body_left != 16'd0) begin
                if (!in_cookie)
                    hash_open = hash_byte(hash_open, b);
                body_left = body_left - 16'd1;
                if (body_left == 16'd0)
                    close_option();
            end else begin
                hash_open = hash_byte(hash_open, b);
                hdr_word  = {hdr_word[23:0], b};
                hdr_count = hdr_count + 3'd1;
                if (hdr_count == 3'd4) begin
                    hdr_count = 3'd0;
                    in_cookie = (hdr_word[31:16] == cookie_code);
                    if (in_cookie)
                        hash_open = hash_kept;
                    body_left = hdr_word[15:0];
                    if (body_left == 16'd0)
                        close_option();
                end
            end
        end
    endfunction

    // result checking and receiver stalls
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("result word with no record outstanding");
                fault_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_well_formed !== want.well_formed) begin
                    $error("well_formed: expected %0d, got %0d",
                           want.well_formed, out_well_formed);
                    fault_count++;
                end
                if (out_kept_length !== want.kept_length) begin
                    $error("kept_length: expected %0d, got %0d",
                           want.kept_length, out_kept_length);
                    fault_count++;
                end
                if (out_hash !== want.option_hash) begin
                    $error("option_hash: expected %h, got %h", want.option_hash, out_hash);
                    fault_count++;
                end
            end
        end
        if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off--;
        end else begin
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (in_valid && !in_ready)
            input_waits++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    task automatic send_word(input logic act, input logic [7:0] b);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        in_valid  <= 1'b1;
        in_action <= act;
        in_byte   <= b;
        do @(posedge clk); while (!in_ready);
        words_sent++;
        track_word(act, b);
    endtask

    task automatic send_record();
        foreach (record_buf[k])
            send_word(ACT_DATA, record_buf[k]);
        record_buf.delete();
        send_word(ACT_END, 8'($urandom));
        records_sent++;
    endtask

    function automatic void put_header(input logic [15:0] code, input logic [15:0] len);
        record_buf.push_back(code[15:8]);
        record_buf.push_back(code[7:0]);
        record_buf.push_back(len[15:8]);
        record_buf.push_back(len[7:0]);
    endfunction

    function automatic void put_option(input logic [15:0] code, input logic [15:0] len);
        put_header(code, len);
        repeat (len) record_buf.push_back(8'($urandom));
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(9))
            0, 1, 2: return cookie_code;
            3:       return cookie_code ^ (16'd1 << $urandom_range(15));
            4:       return 16'h0000;
            5:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_cookie(input logic [15:0] code);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_code  <= code;
        do @(posedge clk); while (!cfg_ready);
        cookie_code = code;
        cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_record();
        int style;
        int cut;
        style = $urandom_range(99);
        if (style < 8) begin
            repeat ($urandom_range(12)) record_buf.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(4))
                put_option(pick_code(), ($urandom_range(4) == 0) ? 16'($urandom_range(24, 7))
                                                                 : 16'($urandom_range(6)));
            if (style >= 88 && record_buf.size() != 0) begin
                cut = $urandom_range((record_buf.size() < 6) ? record_buf.size() : 6, 1);
                repeat (cut) void'(record_buf.pop_back());
            end
        end
        send_record();
    endtask

    task automatic test_directed();
        send_record();
        put_header(16'h0000, 16'd0);
        send_record();
        put_option(COOKIE_RESET, 16'd2);
        send_record();
        put_header(16'hFFFF, 16'd1);
        record_buf.push_back(8'hFF);
        send_record();
        // truncated header
        record_buf.push_back(8'h00);
        record_buf.push_back(8'hFF);
        send_record();
        // body runs past the end
        put_header(16'h0001, 16'd3);
        record_buf.push_back(8'hA5);
        send_record();
    endtask

    task automatic test_cookie_register();
        logic [15:0] codes[5] = '{16'h0000, 16'hFFFF, 16'h5A3C, 16'h8001, COOKIE_RESET};
        foreach (codes[i]) begin
            write_cookie(codes[i]);
            put_option(codes[i], 16'd2);
            put_option(codes[i] ^ 16'h0001, 16'd1);
            send_record();
            put_option(codes[i] ^ 16'h8000, 16'd0);
            put_option(codes[i], 16'd3);
            put_option(16'd10, 16'd2);
            send_record();
            put_option(codes[i], 16'd0);
            send_record();
        end
    endtask

    task automatic test_random_traffic();
        int send_mix[4] = '{0, 74, 0, 31};
        int stall_mix[4] = '{0, 0, 74, 31};
        int stop_at;
        for (int p = 0; p < 4; p++) begin
            write_cookie((p == 3) ? COOKIE_RESET : 16'($urandom));
            send_idle_pct = send_mix[p];
            stall_pct     = stall_mix[p];
            stop_at       = words_sent + 90;
            while (words_sent < stop_at)
                send_random_record();
        end
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_input_backpressure();
        wait_idle();
        hold_off = 300;
        repeat (24) begin
            if ($urandom_range(2) == 0)
                put_option(pick_code(), 16'($urandom_range(3)));
            send_record();
        end
        wait_idle();
    endtask

    initial begin
        restart_record();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_cookie_register();
        test_random_traffic();
        test_input_backpressure();
        wait_idle();
        $display("sent %0d records in %0d words, checked %0d results",
                 records_sent, words_sent, results_seen);
        $display("%0d cookie code writes, input held off for %0d cycles",
                 cfg_writes, input_waits);
        if (fault_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* sim.f */
rtl/eofh_pkg.sv
rtl/edns_option_filter_hash_core.sv
rtl/eofh_checker.sv
tb/sv/testbench.sv
